>>> rtl/core/bc1_pkg.sv
package bc1_pkg;

   localparam int unsigned ColorWidth = 16;
   localparam int unsigned IndexWidth = 32;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned PosWidth   = 2;
   localparam int unsigned PalSize    = 4;

   localparam logic [CountWidth-1:0] CountMax = 3'd4;
   // x/3 == (x*171) >> 9 for every x up to 255
   localparam logic [7:0] Div3Mul   = 8'd171;
   localparam int unsigned Div3Shift = 9;
   localparam logic [ColorWidth-1:0] Transparent = 16'h0000;

   typedef struct packed {
      logic [ColorWidth-1:0] endpoint_zero;
      logic [ColorWidth-1:0] endpoint_one;
      logic [IndexWidth-1:0] index_bits;
      logic [CountWidth-1:0] valid_columns;
      logic [CountWidth-1:0] valid_rows;
   } req_type;

   typedef struct packed {
      logic [ColorWidth-1:0] pixel;
      logic [PosWidth-1:0]   column;
      logic [PosWidth-1:0]   row;
      logic                  last;
   } rsp_type;

   typedef logic [PalSize-1:0][ColorWidth-1:0] palette_type;

   function automatic logic [CountWidth-1:0] clamp_count(input logic [CountWidth-1:0] v);
      clamp_count = (v > CountMax) ? CountMax : v;
   endfunction

   function automatic logic [7:0] div3(input logic [7:0] x);
      logic [15:0] prod;
      prod = x * Div3Mul;
      div3 = 8'(prod >> Div3Shift);
   endfunction

   // RGBA5551 from 5/6/5 components, green low bit dropped, alpha set
   function automatic logic [ColorWidth-1:0] pack5551(input logic [4:0] r5,
                                                       input logic [5:0] g6,
                                                       input logic [4:0] b5);
      pack5551 = {r5, g6[5:1], b5, 1'b1};
   endfunction

endpackage

>>> rtl/core/bc1_palette.sv
module bc1_palette (
   input  logic [bc1_pkg::ColorWidth-1:0] endpoint_zero,
   input  logic [bc1_pkg::ColorWidth-1:0] endpoint_one,
   output bc1_pkg::palette_type           palette
);
   import bc1_pkg::*;

   logic [4:0] r0, r1, b0, b1;
   logic [5:0] g0, g1;
   logic [7:0] r_2a, r_2b, g_2a, g_2b, b_2a, b_2b;
   logic [7:0] r_sum, g_sum, b_sum;
   logic [7:0] r_t0, r_t1, g_t0, g_t1, b_t0, b_t1;

   assign r0 = endpoint_zero[15:11];
   assign g0 = endpoint_zero[10:5];
   assign b0 = endpoint_zero[4:0];
   assign r1 = endpoint_one[15:11];
   assign g1 = endpoint_one[10:5];
   assign b1 = endpoint_one[4:0];

   // weighted sums, 2a+b and a+2b, and plain sums a+b
   assign r_2a  = {2'b0, r0, 1'b0} + {3'b0, r1};
   assign r_2b  = {3'b0, r0} + {2'b0, r1, 1'b0};
   assign g_2a  = {1'b0, g0, 1'b0} + {2'b0, g1};
   assign g_2b  = {2'b0, g0} + {1'b0, g1, 1'b0};
   assign b_2a  = {2'b0, b0, 1'b0} + {3'b0, b1};
   assign b_2b  = {3'b0, b0} + {2'b0, b1, 1'b0};
   assign r_sum = {3'b0, r0} + {3'b0, r1};
   assign g_sum = {2'b0, g0} + {2'b0, g1};
   assign b_sum = {3'b0, b0} + {3'b0, b1};

   assign r_t0 = div3(r_2a);
   assign r_t1 = div3(r_2b);
   assign g_t0 = div3(g_2a);
   assign g_t1 = div3(g_2b);
   assign b_t0 = div3(b_2a);
   assign b_t1 = div3(b_2b);

   always_comb begin
      palette[0] = pack5551(r0, g0, b0);
      palette[1] = pack5551(r1, g1, b1);
      if (endpoint_zero > endpoint_one) begin
         palette[2] = pack5551(r_t0[4:0], g_t0[5:0], b_t0[4:0]);
         palette[3] = pack5551(r_t1[4:0], g_t1[5:0], b_t1[4:0]);
      end else begin
         palette[2] = pack5551(r_sum[5:1], g_sum[6:1], b_sum[5:1]);
         palette[3] = Transparent;
      end
   end

endmodule

>>> rtl/core/bc1_pixel_walk.sv
module bc1_pixel_walk (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bc1_pkg::IndexWidth-1:0] index_bits,
   input  logic [bc1_pkg::CountWidth-1:0] valid_columns,
   input  logic [bc1_pkg::CountWidth-1:0] valid_rows,
   input  bc1_pkg::palette_type           palette,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bc1_pkg::rsp_type               rsp
);
   import bc1_pkg::*;

   logic                  blk_valid_ff, blk_valid_in;
   palette_type           pal_ff;
   logic [IndexWidth-1:0] idx_ff;
   logic [CountWidth-1:0] ncol_ff, nrow_ff;
   logic [PosWidth-1:0]   col_ff, col_in, row_ff, row_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [CountWidth-1:0] ncol_req, nrow_req, ncol_m1, nrow_m1;
   logic                  req_empty, out_free, advance, col_end, at_end, take;
   logic [4:0]            bit_pos;
   logic [1:0]            sel;

   assign ncol_req  = clamp_count(valid_columns);
   assign nrow_req  = clamp_count(valid_rows);
   assign req_empty = (ncol_req == '0) || (nrow_req == '0);

   assign ncol_m1 = ncol_ff - 3'd1;
   assign nrow_m1 = nrow_ff - 3'd1;
   assign col_end = (col_ff == ncol_m1[PosWidth-1:0]);
   assign at_end  = col_end && (row_ff == nrow_m1[PosWidth-1:0]);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = blk_valid_ff && out_free;
   assign req_ready = !blk_valid_ff || (advance && at_end);
   // empty blocks are taken and dropped
   assign take      = req_valid && req_ready && !req_empty;

   assign bit_pos = {row_ff, col_ff, 1'b0};
   assign sel     = idx_ff[bit_pos +: 2];

   always_comb begin
      blk_valid_in = blk_valid_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (advance) begin
         if (at_end) begin
            blk_valid_in = 1'b0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_ff + 2'd1;
         end else begin
            col_in = col_ff + 2'd1;
         end
      end
      if (take) begin
         blk_valid_in = 1'b1;
         col_in       = '0;
         row_in       = '0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in  = 1'b1;
         rsp_in.pixel  = pal_ff[sel];
         rsp_in.column = col_ff;
         rsp_in.row    = row_ff;
         rsp_in.last   = at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         blk_valid_ff <= blk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      rsp_ff <= rsp_in;
      if (take) begin
         pal_ff  <= palette;
         idx_ff  <= index_bits;
         ncol_ff <= ncol_req;
         nrow_ff <= nrow_req;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/core/bc1_block_to_rgba5551.sv
// BC1 block to RGBA5551 pixel decoder.
// Each accepted block is captured into the walk registers; its pixels then pass through
// the result register, columns x rows pixels per block (16 for a full block), one pixel
//   per cycle while rsp_ready holds; a block with a zero count is taken and gives no pixels.
// Reset: synchronous, active high; clears the block and result valid flags only.
module bc1_block_to_rgba5551 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bc1_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bc1_pkg::rsp_type rsp
);
   import bc1_pkg::*;

   // palette built straight off the input item, captured on acceptance
   palette_type palette;

   bc1_palette u_palette (
      .endpoint_zero (req.endpoint_zero),
      .endpoint_one  (req.endpoint_one),
      .palette       (palette)
   );

   // holds one block, walks its valid positions in row-major order;
   // the next block is taken in the cycle its predecessor's last pixel
   // moves into the result register
   bc1_pixel_walk u_walk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .index_bits    (req.index_bits),
      .valid_columns (req.valid_columns),
      .valid_rows    (req.valid_rows),
      .palette       (palette),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp)
   );

endmodule

>>> rtl/core/bc1_checker.sv
module bc1_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bc1_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bc1_pkg::rsp_type rsp
);
   import bc1_pkg::*;

   logic rsp_take;
   assign rsp_take = rsp_valid && rsp_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // pixels of one block stream without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp.last |=> rsp_valid)
      else $error("gap inside a block");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp.last |=>
         (rsp.row == $past(rsp.row)) || (rsp.row == 2'($past(rsp.row) + 2'd1)))
      else $error("row order broken inside a block");

   // an accepted item carries only known bits
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !$isunknown(req))
      else $error("accepted request has unknown bits");

endmodule

bind bc1_block_to_rgba5551 bc1_checker u_bc1_checker (.*);

>>> tb/bc1_block_to_rgba5551_tb.sv
`timescale 1ns / 1ps

module bc1_block_to_rgba5551_tb;
   import bc1_pkg::*;

   localparam int unsigned CycleLimit   = 200000;
   localparam int unsigned DrainCycles  = 24;    // well past the latency through the result register
   localparam int unsigned RandomBlocks = 100;   // per handshake phase, three phases

   // how the expected pixels of a table row are obtained
   typedef enum logic [1:0] {
      CHECK_PREDICT,    // from the decoder model below
      CHECK_ONE_PIXEL,  // 1x1 block, pixel value typed into the table
      CHECK_SILENT      // zero count, no pixels at all
   } check_kind_type;

   typedef struct {
      req_type        blk;
      check_kind_type kind;
      logic [15:0]    shade;
   } table_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   rsp_type       pixels_due[$];   // decoded pixels still to come out, oldest first
   table_row_type directed_rows[$];
   int unsigned   send_idle_pct = 18;
   int unsigned   recv_idle_pct = 61;
   int unsigned   cycle_count   = 0;
   int unsigned   error_count   = 0;
   int unsigned   blocks_sent   = 0;
   int unsigned   pixels_seen   = 0;

   bc1_block_to_rgba5551 DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   always #2 clock = ~clock;

   // global watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   // 5/6/5 components to RGBA5551, green narrowed by dropping its low bit
   function automatic logic [15:0] to_5551(input int unsigned r, input int unsigned g,
                                           input int unsigned b);
      logic [4:0] r5;
      logic [5:0] g6;
      logic [4:0] b5;
      r5 = r[4:0];
      g6 = g[5:0];
      b5 = b[4:0];
      return {r5, g6[5:1], b5, 1'b1};
   endfunction

   // Decodes one block and queues its pixels in row-major order.
   function automatic void decode_block(input req_type blk);
      logic [15:0] shade[4];
      int unsigned r0, g0, b0, r1, g1, b1;
      int unsigned ncol, nrow, k, sel, n;
      rsp_type px;
      r0 = blk.endpoint_zero[15:11];
      g0 = blk.endpoint_zero[10:5];
      b0 = blk.endpoint_zero[4:0];
      r1 = blk.endpoint_one[15:11];
      g1 = blk.endpoint_one[10:5];
      b1 = blk.endpoint_one[4:0];
      shade[0] = to_5551(r0, g0, b0);
      shade[1] = to_5551(r1, g1, b1);
      if (blk.endpoint_zero > blk.endpoint_one) begin
         shade[2] = to_5551((2*r0 + r1) / 3, (2*g0 + g1) / 3, (2*b0 + b1) / 3);
         shade[3] = to_5551((r0 + 2*r1) / 3, (g0 + 2*g1) / 3, (b0 + 2*b1) / 3);
      end else begin
         shade[2] = to_5551((r0 + r1) / 2, (g0 + g1) / 2, (b0 + b1) / 2);
         shade[3] = 16'h0000;
      end
      // counts above four saturate; zero gives nothing
      ncol = (blk.valid_columns > 3'd4) ? 4 : blk.valid_columns;
      nrow = (blk.valid_rows > 3'd4) ? 4 : blk.valid_rows;
      n = 0;
      for (int unsigned y = 0; y < nrow; y++) begin
         for (int unsigned x = 0; x < ncol; x++) begin
            k = y*4 + x;
            sel = (blk.index_bits >> (2*k)) & 32'h3;
            px.pixel  = shade[sel];
            px.column = x[1:0];
            px.row    = y[1:0];
            px.last   = (n + 1 == ncol*nrow);
            pixels_due.push_back(px);
            n++;
         end
      end
   endfunction

   function automatic table_row_type make_row(input logic [15:0] c0, input logic [15:0] c1,
                                              input logic [31:0] idx, input logic [2:0] cols,
                                              input logic [2:0] rows,
                                              input check_kind_type kind,
                                              input logic [15:0] shade);
      table_row_type t;
      t.blk.endpoint_zero = c0;
      t.blk.endpoint_one  = c1;
      t.blk.index_bits    = idx;
      t.blk.valid_columns = cols;
      t.blk.valid_rows    = rows;
      t.kind  = kind;
      t.shade = shade;
      return t;
   endfunction

   // Mostly in-range counts; now and then a zero or an over-range count.
   function automatic req_type random_block();
      req_type blk;
      blk.endpoint_zero = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 15))
         0:       blk.endpoint_one = blk.endpoint_zero;       // equal, not greater
         1:       blk.endpoint_one = blk.endpoint_zero - 16'd1;
         2:       blk.endpoint_one = 16'hFFFF;
         3:       blk.endpoint_one = 16'h0000;
         default: blk.endpoint_one = 16'($urandom_range(0, 65535));
      endcase
      blk.index_bits = $urandom;
      if ($urandom_range(0, 9) < 8) begin
         blk.valid_columns = 3'($urandom_range(1, 4));
         blk.valid_rows    = 3'($urandom_range(1, 4));
      end else begin
         blk.valid_columns = 3'($urandom_range(0, 7));
         blk.valid_rows    = 3'($urandom_range(0, 7));
      end
      return blk;
   endfunction

   // Offers one block, waits for acceptance, then queues what it should produce.
   // valid is only lowered on an idle cycle, so back-to-back items keep it high.
   task automatic send_block(input req_type blk, input check_kind_type kind,
                             input logic [15:0] shade);
      rsp_type px;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req       <= blk;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      blocks_sent++;
      case (kind)
         CHECK_PREDICT: decode_block(blk);
         CHECK_ONE_PIXEL: begin
            px.pixel  = shade;
            px.column = '0;
            px.row    = '0;
            px.last   = 1'b1;
            pixels_due.push_back(px);
         end
         default: ;  // zero count: nothing due
      endcase
   endtask

   // Result side: checks each accepted pixel against the oldest one due,
   // and stalls at random.
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            pixels_seen++;
            if (pixels_due.size() == 0) begin
               report_mismatch("pixel with nothing due", 32'(rsp), 0);
            end else begin
               due = pixels_due.pop_front();
               if (rsp.pixel !== due.pixel)
                  report_mismatch("pixel", 32'(rsp.pixel), 32'(due.pixel));
               if (rsp.column !== due.column)
                  report_mismatch("column", 32'(rsp.column), 32'(due.column));
               if (rsp.row !== due.row)
                  report_mismatch("row", 32'(rsp.row), 32'(due.row));
               if (rsp.last !== due.last)
                  report_mismatch("last", 32'(rsp.last), 32'(due.last));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      // 1x1 rows: palette entry picked straight from the endpoints
      directed_rows.push_back(make_row(16'h0000, 16'h0000, 32'h0, 3'd1, 3'd1,
                                       CHECK_ONE_PIXEL, 16'h0001));
      directed_rows.push_back(make_row(16'hFFFF, 16'h0000, 32'h0, 3'd1, 3'd1,
                                       CHECK_ONE_PIXEL, 16'hFFFF));
      directed_rows.push_back(make_row(16'hFFFF, 16'h0000, 32'h1, 3'd1, 3'd1,
                                       CHECK_ONE_PIXEL, 16'h0001));
      // endpoint 0 below endpoint 1: index 3 is transparent black
      directed_rows.push_back(make_row(16'h0000, 16'hFFFF, 32'h3, 3'd1, 3'd1,
                                       CHECK_ONE_PIXEL, 16'h0000));
      // zero counts give no pixels
      directed_rows.push_back(make_row(16'h1234, 16'h5678, 32'hFFFF_FFFF, 3'd0, 3'd4,
                                       CHECK_SILENT, 16'h0));
      directed_rows.push_back(make_row(16'h5678, 16'h1234, 32'hFFFF_FFFF, 3'd4, 3'd0,
                                       CHECK_SILENT, 16'h0));
      directed_rows.push_back(make_row(16'hFFFF, 16'hFFFF, 32'h0, 3'd0, 3'd0,
                                       CHECK_SILENT, 16'h0));
      // a 1x1 mean pick, then full blocks: thirds, mean, equal endpoints, greater by one
      directed_rows.push_back(make_row(16'h0000, 16'hFFFF, 32'h2, 3'd1, 3'd1,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 3'd4, 3'd4,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 3'd4, 3'd4,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'h8410, 16'h8410, 32'hFFFF_FFFF, 3'd4, 3'd4,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'h8411, 16'h8410, 32'hAAAA_AAAA, 3'd4, 3'd4,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'hFFFF, 16'hFFFF, 32'h5555_5555, 3'd4, 3'd4,
                                       CHECK_PREDICT, 16'h0));
      // over-range counts saturate at four
      directed_rows.push_back(make_row(16'hF800, 16'h07E0, 32'h5555_5555, 3'd7, 3'd7,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'h001F, 16'hF800, 32'h1B1B_1B1B, 3'd5, 3'd2,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'h07E0, 16'h001F, 32'h9C63_27D8, 3'd3, 3'd6,
                                       CHECK_PREDICT, 16'h0));
      // partial blocks: pick indices from the right bit pairs
      directed_rows.push_back(make_row(16'hA5A5, 16'h5A5A, 32'h8040_2010, 3'd1, 3'd4,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'h5A5A, 16'hA5A5, 32'h0000_00E4, 3'd4, 3'd1,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'h7BEF, 16'h8430, 32'h0F0F_0F0F, 3'd3, 3'd2,
                                       CHECK_PREDICT, 16'h0));
      directed_rows.push_back(make_row(16'hFFFE, 16'hFFFF, 32'hF00F_C33C, 3'd2, 3'd3,
                                       CHECK_PREDICT, 16'h0));

      // synchronous reset, held high from time zero, then released
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 1: sender idles lightly, receiver stalls heavily
      foreach (directed_rows[i])
         send_block(directed_rows[i].blk, directed_rows[i].kind, directed_rows[i].shade);
      repeat (RandomBlocks) send_block(random_block(), CHECK_PREDICT, 16'h0);

      // phase 2: the other way round
      send_idle_pct = 61;
      recv_idle_pct <= 18;
      repeat (RandomBlocks) send_block(random_block(), CHECK_PREDICT, 16'h0);

      // phase 3: full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      repeat (RandomBlocks) send_block(random_block(), CHECK_PREDICT, 16'h0);
      req_valid <= 1'b0;

      // drain, then give any stray pixel time to show
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("blocks sent: %0d (directed table plus random), pixels checked: %0d",
               blocks_sent, pixels_seen);
      $display("covered: thirds/mean/transparent palettes, zero and saturated counts, "
               , "three handshake pressure phases; mismatches: %0d", error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> bc1_block_to_rgba5551.f
rtl/core/bc1_pkg.sv
rtl/core/bc1_palette.sv
rtl/core/bc1_pixel_walk.sv
rtl/core/bc1_block_to_rgba5551.sv
rtl/core/bc1_checker.sv
tb/bc1_block_to_rgba5551_tb.sv
